@@ hw/rtl/bds_pkg.sv @@
// ----------------------------------------------------------------------------
// bds_pkg
// Shared constants and types for the bounded data stack.
// ----------------------------------------------------------------------------
package bds_pkg;

    localparam int DEPTH       = 128;
    localparam int ADDR_W      = $clog2(DEPTH);
    localparam int PTR_W       = $clog2(DEPTH + 1);
    localparam int WORD_W      = 64;
    localparam int OP_W        = 3;
    localparam int ST_W        = 2;
    localparam int DEPTH_OUT_W = 8;
    localparam int S_DATA_W    = 72;
    localparam int M_DATA_W    = 80;

    localparam logic [OP_W-1:0] OP_PUSH  = 3'd0;
    localparam logic [OP_W-1:0] OP_POP   = 3'd1;
    localparam logic [OP_W-1:0] OP_PEEK  = 3'd2;
    localparam logic [OP_W-1:0] OP_DUP   = 3'd3;
    localparam logic [OP_W-1:0] OP_SWAP  = 3'd4;
    localparam logic [OP_W-1:0] OP_CLEAR = 3'd5;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_OVER  = 2'd1;
    localparam logic [ST_W-1:0] ST_UNDER = 2'd2;

    localparam logic [1:0] ADDR_TOP  = 2'd0;
    localparam logic [1:0] ADDR_NEXT = 2'd1;
    localparam logic [1:0] ADDR_FREE = 2'd2;

    localparam logic [1:0] WD_WORD  = 2'd0;
    localparam logic [1:0] WD_RDATA = 2'd1;
    localparam logic [1:0] WD_HOLD  = 2'd2;

    localparam logic [1:0] PTR_KEEP = 2'd0;
    localparam logic [1:0] PTR_INC  = 2'd1;
    localparam logic [1:0] PTR_DEC  = 2'd2;
    localparam logic [1:0] PTR_CLR  = 2'd3;

    typedef struct packed {
        logic            load;
        logic            mem_we;
        logic [1:0]      addr_sel;
        logic [1:0]      wdata_sel;
        logic            hold_load;
        logic            rd_load;
        logic [1:0]      ptr_op;
        logic            out_load;
        logic [ST_W-1:0] status;
    } bds_cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            empty;
        logic            below_two;
        logic            full;
        logic            out_busy;
    } bds_stat_t;

endpackage

@@ hw/rtl/bds_ram.sv @@
// ----------------------------------------------------------------------------
// bds_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module bds_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/bds_ctrl.sv @@
// ----------------------------------------------------------------------------
// bds_ctrl
// Sequencer: checks each operation against the fill level and steps the
// datapath through its memory accesses.
// ----------------------------------------------------------------------------
module bds_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  bds_pkg::bds_stat_t stat,
    output bds_pkg::bds_cmd_t  cmd
);
    import bds_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DEC  = 3'd1;
    localparam logic [2:0] S_RDT  = 3'd2;
    localparam logic [2:0] S_DUPW = 3'd3;
    localparam logic [2:0] S_SW1  = 3'd4;
    localparam logic [2:0] S_SW2  = 3'd5;
    localparam logic [2:0] S_SW3  = 3'd6;
    localparam logic [2:0] S_DONE = 3'd7;

    logic [2:0]      state_reg, state_next;
    logic [ST_W-1:0] st_reg, st_next;

    assign in_ready = (state_reg == S_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            st_reg    <= ST_OK;
        end else begin
            state_reg <= state_next;
            st_reg    <= st_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        st_next    = st_reg;
        cmd        = '0;
        cmd.status = st_reg;
        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    st_next    = ST_OK;
                    state_next = S_DEC;
                end
            end
            S_DEC: begin
                state_next = S_DONE;
                case (stat.op)
                    OP_PUSH: begin
                        if (stat.full) begin
                            st_next = ST_OVER;
                        end else begin
                            cmd.mem_we    = 1'b1;
                            cmd.addr_sel  = ADDR_FREE;
                            cmd.wdata_sel = WD_WORD;
                            cmd.ptr_op    = PTR_INC;
                        end
                    end
                    OP_POP, OP_PEEK: begin
                        if (stat.empty) begin
                            st_next = ST_UNDER;
                        end else begin
                            cmd.addr_sel = ADDR_TOP;
                            state_next   = S_RDT;
                        end
                    end
                    OP_DUP: begin
                        if (stat.full) begin
                            st_next = ST_OVER;
                        end else if (stat.empty) begin
                            st_next = ST_UNDER;
                        end else begin
                            cmd.addr_sel = ADDR_TOP;
                            state_next   = S_DUPW;
                        end
                    end
                    OP_SWAP: begin
                        if (stat.below_two) begin
                            st_next = ST_UNDER;
                        end else begin
                            cmd.addr_sel = ADDR_TOP;
                            state_next   = S_SW1;
                        end
                    end
                    OP_CLEAR: begin
                        if (stat.empty) begin
                            st_next = ST_UNDER;
                        end else begin
                            cmd.ptr_op = PTR_CLR;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_RDT: begin
                cmd.rd_load = 1'b1;
                if (stat.op == OP_POP) begin
                    cmd.ptr_op = PTR_DEC;
                end
                state_next = S_DONE;
            end
            S_DUPW: begin
                cmd.mem_we    = 1'b1;
                cmd.addr_sel  = ADDR_FREE;
                cmd.wdata_sel = WD_RDATA;
                cmd.ptr_op    = PTR_INC;
                state_next    = S_DONE;
            end
            S_SW1: begin
                cmd.hold_load = 1'b1;
                cmd.addr_sel  = ADDR_NEXT;
                state_next    = S_SW2;
            end
            S_SW2: begin
                cmd.mem_we    = 1'b1;
                cmd.addr_sel  = ADDR_TOP;
                cmd.wdata_sel = WD_RDATA;
                state_next    = S_SW3;
            end
            S_SW3: begin
                cmd.mem_we    = 1'b1;
                cmd.addr_sel  = ADDR_NEXT;
                cmd.wdata_sel = WD_HOLD;
                state_next    = S_DONE;
            end
            S_DONE: begin
                if (!stat.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ hw/rtl/bds_dp.sv @@
// ----------------------------------------------------------------------------
// bds_dp
// Datapath: stack pointer, entry store, swap holding register and the
// result register.
// ----------------------------------------------------------------------------
module bds_dp (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [bds_pkg::S_DATA_W-1:0]  s_tdata,
    input  bds_pkg::bds_cmd_t             cmd,
    output bds_pkg::bds_stat_t            stat,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [bds_pkg::M_DATA_W-1:0]  m_tdata
);
    import bds_pkg::*;

    logic [OP_W-1:0]     op_reg;
    logic [WORD_W-1:0]   word_reg;
    logic [PTR_W-1:0]    ptr_reg, ptr_next;
    logic [WORD_W-1:0]   hold_reg;
    logic [WORD_W-1:0]   rd_reg;
    logic                m_valid_reg;
    logic [M_DATA_W-1:0] m_data_reg;

    logic [PTR_W-1:0]    ptr_m1, ptr_m2;
    logic [ADDR_W-1:0]   ram_addr;
    logic [WORD_W-1:0]   ram_wdata, ram_rdata;
    logic                empty_w, full_w;

    assign ptr_m1  = ptr_reg - PTR_W'(1);
    assign ptr_m2  = ptr_reg - PTR_W'(2);
    assign empty_w = (ptr_reg == '0);
    assign full_w  = (ptr_reg == PTR_W'(DEPTH));

    always_comb begin
        case (cmd.addr_sel)
            ADDR_TOP:  ram_addr = ptr_m1[ADDR_W-1:0];
            ADDR_NEXT: ram_addr = ptr_m2[ADDR_W-1:0];
            default:   ram_addr = ptr_reg[ADDR_W-1:0];
        endcase
        case (cmd.wdata_sel)
            WD_RDATA: ram_wdata = ram_rdata;
            WD_HOLD:  ram_wdata = hold_reg;
            default:  ram_wdata = word_reg;
        endcase
        case (cmd.ptr_op)
            PTR_INC: ptr_next = ptr_reg + PTR_W'(1);
            PTR_DEC: ptr_next = ptr_m1;
            PTR_CLR: ptr_next = '0;
            default: ptr_next = ptr_reg;
        endcase
    end

    bds_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (cmd.mem_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            ptr_reg <= ptr_next;
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg   <= s_tdata[OP_W-1:0];
            word_reg <= s_tdata[OP_W+WORD_W-1:OP_W];
            rd_reg   <= '0;
        end else if (cmd.rd_load) begin
            rd_reg <= ram_rdata;
        end
        if (cmd.hold_load) begin
            hold_reg <= ram_rdata;
        end
        if (cmd.out_load) begin
            m_data_reg <= {4'b0000, full_w, empty_w, DEPTH_OUT_W'(ptr_reg),
                           cmd.status, rd_reg};
        end
    end

    assign stat.op        = op_reg;
    assign stat.empty     = empty_w;
    assign stat.below_two = (ptr_reg < PTR_W'(2));
    assign stat.full      = full_w;
    assign stat.out_busy  = m_valid_reg && !m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // fill level stays within bounds
    a_ptr_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        ptr_reg <= PTR_W'(DEPTH))
        else $error("stack pointer beyond depth");

    // free slot written only when room is left
    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.mem_we && cmd.addr_sel == ADDR_FREE) |-> !full_w)
        else $error("write past the top of a full stack");

    // result flags match the fill level captured with them
    a_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> (m_data_reg[74] == (ptr_reg == '0)
                          && m_data_reg[75] == (ptr_reg == PTR_W'(DEPTH))))
        else $error("empty or full flag inconsistent with depth");

    // a pending result is never overwritten
    a_no_clobber: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid_reg || m_tready))
        else $error("result register overwritten while pending");

endmodule

@@ hw/rtl/bounded_data_stack.sv @@
// ----------------------------------------------------------------------------
// bounded_data_stack
// Bounded LIFO stack of 64-bit words with push, pop, peek, dup, swap, clear.
// ----------------------------------------------------------------------------
// Push, clear, errors and unused opcodes go from decode to the result register;
// pop, peek and dup add a state after the read, and swap adds S_SW1 to S_SW3.
// Words are handled one at a time over the single-port entry store.
// A pending result does not block acceptance of the next word.
// Synchronous active-low reset empties the stack; stored words are not cleared.
module bounded_data_stack (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [2:0] opcode, [66:3] push_value, [71:67] zero
    input  logic [bds_pkg::S_DATA_W-1:0]  s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [63:0] read_value, [65:64] status, [73:66] depth, [74] is_empty,
    // [75] is_full, [79:76] zero
    output logic [bds_pkg::M_DATA_W-1:0]  m_tdata
);
    import bds_pkg::*;

    bds_cmd_t  cmd;
    bds_stat_t stat;

    bds_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bds_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
